@@ design/kssb_pkg.sv @@
// kssb_pkg: shared types and constants for the keyboard serial byte sender
// depends on nothing; used by kssb_engine and the top level
`timescale 1ns / 1ps

package kssb_pkg;

    // default geometry of the chunk ring
    localparam int CHUNK_SLOTS_DEF = 64;
    localparam int CHUNK_BYTES_DEF = 8;

    // register reset and protocol constants
    localparam logic [7:0] RATE_RESET     = 8'd16;
    localparam logic [3:0] BITS_PER_BYTE  = 4'd8;
    localparam logic [1:0] HIGH_TICKS_SET = 2'd2;

    // transmit sequencer phases, one-hot
    typedef enum logic [4:0] {
        PH_INIT = 5'b00001,
        PH_IDLE = 5'b00010,
        PH_HIGH = 5'b00100,
        PH_FALL = 5'b01000,
        PH_LOW  = 5'b10000
    } t_phase;

    // result of one item
    typedef struct packed {
        logic sending;
        logic push_dropped;
        logic reset_ack_request;
        logic data_drive;
        logic clock_drive;
    } t_res;

endpackage

@@ design/kssb_store.sv @@
// kssb_store: chunk byte memory and chunk length memory, registered read
// depends on nothing outside this file
`timescale 1ns / 1ps

module kssb_store #(
    parameter int CHUNK_SLOTS = 64,
    parameter int CHUNK_BYTES = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_byte_we,
    input  logic [$clog2(CHUNK_SLOTS*CHUNK_BYTES)-1:0]  i_byte_waddr,
    input  logic [7:0]                                  i_byte_wdata,
    input  logic [$clog2(CHUNK_SLOTS*CHUNK_BYTES)-1:0]  i_byte_raddr,
    output logic [7:0]                                  o_byte_rdata,
    input  logic                                        i_len_we,
    input  logic [$clog2(CHUNK_SLOTS)-1:0]              i_len_waddr,
    input  logic [$clog2(CHUNK_BYTES+1)-1:0]            i_len_wdata,
    input  logic [$clog2(CHUNK_SLOTS)-1:0]              i_len_raddr,
    output logic [$clog2(CHUNK_BYTES+1)-1:0]            o_len_rdata
);

    localparam int DEPTH = CHUNK_SLOTS * CHUNK_BYTES;
    localparam int CNT_W = $clog2(CHUNK_BYTES + 1);

    logic [7:0]       r_byte_mem [DEPTH];
    logic [CNT_W-1:0] r_len_mem  [CHUNK_SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_byte_we) begin
            r_byte_mem[i_byte_waddr] <= i_byte_wdata;
        end
        o_byte_rdata <= r_byte_mem[i_byte_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_len_we) begin
            r_len_mem[i_len_waddr] <= i_len_wdata;
        end
        o_len_rdata <= r_len_mem[i_len_raddr];
    end

endmodule

@@ design/kssb_engine.sv @@
// kssb_engine: ring pointers, chunk fill and line transmit sequencer
// depends on kssb_pkg; reads and writes the memories in kssb_store
`timescale 1ns / 1ps

module kssb_engine #(
    parameter int CHUNK_SLOTS = 64,
    parameter int CHUNK_BYTES = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_exec,
    input  logic                                        i_action,
    input  logic                                        i_clock_line,
    input  logic                                        i_data_line,
    input  logic [7:0]                                  i_push_byte,
    input  logic                                        i_chunk_end,
    input  logic [7:0]                                  i_rate_reload,
    output logic                                        o_byte_we,
    output logic [$clog2(CHUNK_SLOTS*CHUNK_BYTES)-1:0]  o_byte_waddr,
    output logic [7:0]                                  o_byte_wdata,
    output logic [$clog2(CHUNK_SLOTS*CHUNK_BYTES)-1:0]  o_byte_raddr,
    input  logic [7:0]                                  i_byte_rdata,
    output logic                                        o_len_we,
    output logic [$clog2(CHUNK_SLOTS)-1:0]              o_len_waddr,
    output logic [$clog2(CHUNK_BYTES+1)-1:0]            o_len_wdata,
    output logic [$clog2(CHUNK_SLOTS)-1:0]              o_len_raddr,
    input  logic [$clog2(CHUNK_BYTES+1)-1:0]            i_len_rdata,
    output kssb_pkg::t_res                              o_res
);

    localparam int SLOT_W = $clog2(CHUNK_SLOTS);
    localparam int CNT_W  = $clog2(CHUNK_BYTES + 1);
    localparam int ADDR_W = $clog2(CHUNK_SLOTS * CHUNK_BYTES);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CHUNK_SLOTS - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(CHUNK_BYTES);
    localparam logic [ADDR_W-1:0] ROW_BYTES = ADDR_W'(CHUNK_BYTES);

    kssb_pkg::t_phase  r_phase, n_phase;
    logic [3:0]        r_bits_sent, n_bits_sent;
    logic [1:0]        r_high_ticks, n_high_ticks;
    logic [7:0]        r_shift, n_shift;
    logic [7:0]        r_rate_count, n_rate_count;
    logic [CNT_W-1:0]  r_byte_index, n_byte_index;
    logic [SLOT_W-1:0] r_read_slot, n_read_slot;
    logic [SLOT_W-1:0] r_write_slot, n_write_slot;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic              r_clock_level, n_clock_level;
    logic              r_data_level, n_data_level;

    logic [SLOT_W-1:0] write_next;
    logic [SLOT_W-1:0] read_next;
    logic [CNT_W-1:0]  fill_new;
    logic [CNT_W-1:0]  index_inc;
    logic [7:0]        rate_dec;
    logic [1:0]        high_inc;
    logic              ack;
    logic              dropped;

    assign write_next = (r_write_slot == LAST_SLOT) ? '0 : r_write_slot + 1'b1;
    assign read_next  = (r_read_slot == LAST_SLOT) ? '0 : r_read_slot + 1'b1;
    assign index_inc  = r_byte_index + 1'b1;
    assign rate_dec   = (r_rate_count != 8'd0) ? r_rate_count - 8'd1 : 8'd0;
    assign high_inc   = r_high_ticks + 2'd1;

    // memory reads follow the head of the ring every cycle
    assign o_byte_raddr = ADDR_W'(r_read_slot) * ROW_BYTES + ADDR_W'(r_byte_index);
    assign o_len_raddr  = r_read_slot;
    assign o_byte_waddr = ADDR_W'(r_write_slot) * ROW_BYTES + ADDR_W'(r_fill);
    assign o_byte_wdata = i_push_byte;
    assign o_len_waddr  = r_write_slot;

    always_comb begin
        n_phase       = r_phase;
        n_bits_sent   = r_bits_sent;
        n_high_ticks  = r_high_ticks;
        n_shift       = r_shift;
        n_rate_count  = r_rate_count;
        n_byte_index  = r_byte_index;
        n_read_slot   = r_read_slot;
        n_write_slot  = r_write_slot;
        n_fill        = r_fill;
        n_clock_level = r_clock_level;
        n_data_level  = r_data_level;
        fill_new      = r_fill;
        o_byte_we     = 1'b0;
        o_len_we      = 1'b0;
        o_len_wdata   = r_fill;
        ack           = 1'b0;
        dropped       = 1'b0;
        if (i_exec && i_action) begin
            if (write_next == r_read_slot) begin
                // ring full: whole push refused
                dropped = 1'b1;
            end else begin
                if (r_fill < FULL_CNT) begin
                    o_byte_we = 1'b1;
                    fill_new  = r_fill + 1'b1;
                end else begin
                    dropped = 1'b1;
                end
                o_len_wdata = fill_new;
                if (i_chunk_end && fill_new != '0) begin
                    o_len_we     = 1'b1;
                    n_write_slot = write_next;
                    n_fill       = '0;
                end else begin
                    n_fill = fill_new;
                end
            end
        end else if (i_exec) begin
            unique case (r_phase)
                kssb_pkg::PH_IDLE: begin
                    if (!i_clock_line) begin
                        ack = 1'b1;
                    end else if (i_data_line) begin
                        n_rate_count = rate_dec;
                        if (rate_dec == 8'd0 && r_read_slot != r_write_slot) begin
                            n_rate_count = i_rate_reload;
                            n_shift      = i_byte_rdata;
                            n_phase      = kssb_pkg::PH_HIGH;
                            n_high_ticks = 2'd0;
                        end
                    end
                end
                kssb_pkg::PH_HIGH: begin
                    n_high_ticks = high_inc;
                    if (high_inc == kssb_pkg::HIGH_TICKS_SET) begin
                        n_data_level = r_shift[7];
                        n_shift      = {r_shift[6:0], 1'b0};
                        n_bits_sent  = r_bits_sent + 4'd1;
                        n_phase      = kssb_pkg::PH_FALL;
                        n_high_ticks = 2'd0;
                    end
                end
                kssb_pkg::PH_FALL: begin
                    n_clock_level = 1'b0;
                    n_phase       = kssb_pkg::PH_LOW;
                end
                kssb_pkg::PH_LOW: begin
                    if (r_bits_sent == kssb_pkg::BITS_PER_BYTE) begin
                        n_bits_sent = 4'd0;
                        if (index_inc >= i_len_rdata) begin
                            n_read_slot  = read_next;
                            n_byte_index = '0;
                        end else begin
                            n_byte_index = index_inc;
                        end
                        n_phase      = kssb_pkg::PH_IDLE;
                        n_data_level = 1'b1;
                    end else begin
                        n_phase = kssb_pkg::PH_HIGH;
                    end
                    n_clock_level = 1'b1;
                end
                default: begin
                    // init and any stray code
                    n_phase       = kssb_pkg::PH_IDLE;
                    n_data_level  = 1'b1;
                    n_clock_level = 1'b1;
                    n_bits_sent   = 4'd0;
                end
            endcase
        end
    end

    always_comb begin
        o_res.clock_drive       = n_clock_level;
        o_res.data_drive        = n_data_level;
        o_res.reset_ack_request = ack;
        o_res.push_dropped      = dropped;
        o_res.sending           = (n_phase == kssb_pkg::PH_HIGH)
                               || (n_phase == kssb_pkg::PH_FALL)
                               || (n_phase == kssb_pkg::PH_LOW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= kssb_pkg::PH_INIT;
            r_bits_sent   <= 4'd0;
            r_high_ticks  <= 2'd0;
            r_rate_count  <= 8'd0;
            r_byte_index  <= '0;
            r_read_slot   <= '0;
            r_write_slot  <= '0;
            r_fill        <= '0;
            r_clock_level <= 1'b1;
            r_data_level  <= 1'b1;
        end else begin
            r_phase       <= n_phase;
            r_bits_sent   <= n_bits_sent;
            r_high_ticks  <= n_high_ticks;
            r_rate_count  <= n_rate_count;
            r_byte_index  <= n_byte_index;
            r_read_slot   <= n_read_slot;
            r_write_slot  <= n_write_slot;
            r_fill        <= n_fill;
            r_clock_level <= n_clock_level;
            r_data_level  <= n_data_level;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL_CNT)
        else $error("chunk fill beyond chunk size");

    a_clock_low_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clock_level |-> r_phase == kssb_pkg::PH_LOW)
        else $error("clock driven low outside the low phase");

    a_send_has_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == kssb_pkg::PH_HIGH || r_phase == kssb_pkg::PH_FALL
         || r_phase == kssb_pkg::PH_LOW) |-> r_read_slot != r_write_slot)
        else $error("sending with an empty ring");

    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits_sent <= kssb_pkg::BITS_PER_BYTE)
        else $error("bit count beyond one byte");

endmodule

@@ design/keyboard_serial_byte_sender.sv @@
// keyboard_serial_byte_sender: top level, stream handshakes, config register, result register
// depends on kssb_pkg, kssb_store and kssb_engine
`timescale 1ns / 1ps

// channel | dir | transfer on                       | payload
// --------+-----+-----------------------------------+-----------------------------------------
// s_axis  | in  | i_s_axis_tvalid & o_s_axis_tready | tuser: action; tlast: chunk_end;
//         |     |                                   | tdata: clock_line, data_line, push_byte
// m_axis  | out | o_m_axis_tvalid & i_m_axis_tready | tdata: clock_drive, data_drive,
//         |     |                                   | reset_ack_request, push_dropped, sending
// cfg     | in  | i_cfg_valid & o_cfg_ready         | i_cfg_data: rate_reload
//
// each item, once taken, first presents the ring head address to the chunk memories,
// then gets the registered read data and executes; a new item is taken in the cycle
// its predecessor executes
// reset is synchronous, active low; it clears pointers and sequencer, memories are
// left as they are (only closed chunks are ever read)
// a result waits in the output register; one more item can be accepted and held behind
// it, then the input stalls until the result is taken; a master stall that covers an
// execute cycle delays that item, and the next transfer, by the length of the stall

module keyboard_serial_byte_sender #(
    parameter int CHUNK_SLOTS = kssb_pkg::CHUNK_SLOTS_DEF,
    parameter int CHUNK_BYTES = kssb_pkg::CHUNK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [0] clock_line, [1] data_line, [9:2] push_byte
    input  logic [0:0]  i_s_axis_tuser,   // [0] action
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [0] clock_drive, [1] data_drive,
                                          // [2] reset_ack_request, [3] push_dropped, [4] sending
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int SLOT_W = $clog2(CHUNK_SLOTS);
    localparam int CNT_W  = $clog2(CHUNK_BYTES + 1);
    localparam int ADDR_W = $clog2(CHUNK_SLOTS * CHUNK_BYTES);

    // item holding register
    logic       r_busy, n_busy;
    logic       r_rd_ok, n_rd_ok;
    logic       r_action;
    logic       r_clock_line;
    logic       r_data_line;
    logic [7:0] r_push_byte;
    logic       r_chunk_end;

    // output register
    logic           r_m_valid, n_m_valid;
    kssb_pkg::t_res r_res;

    logic [7:0] r_rate_reload;

    logic accept;
    logic exec;

    // memory wiring
    logic              byte_we;
    logic [ADDR_W-1:0] byte_waddr;
    logic [7:0]        byte_wdata;
    logic [ADDR_W-1:0] byte_raddr;
    logic [7:0]        byte_rdata;
    logic              len_we;
    logic [SLOT_W-1:0] len_waddr;
    logic [CNT_W-1:0]  len_wdata;
    logic [SLOT_W-1:0] len_raddr;
    logic [CNT_W-1:0]  len_rdata;
    kssb_pkg::t_res    res;

    // execute once read data matches the current ring head and the result slot frees
    assign exec            = r_busy && r_rd_ok && (!r_m_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_busy || exec;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_comb begin
        n_busy = r_busy;
        if (accept) begin
            n_busy = 1'b1;
        end else if (exec) begin
            n_busy = 1'b0;
        end
        // read data lines up in the cycle after the state the item sees was settled
        n_rd_ok = accept ? 1'b0 : r_busy;
        n_m_valid = r_m_valid;
        if (exec) begin
            n_m_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy        <= 1'b0;
            r_rd_ok       <= 1'b0;
            r_m_valid     <= 1'b0;
            r_rate_reload <= kssb_pkg::RATE_RESET;
        end else begin
            r_busy    <= n_busy;
            r_rd_ok   <= n_rd_ok;
            r_m_valid <= n_m_valid;
            if (i_cfg_valid) begin
                r_rate_reload <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action     <= i_s_axis_tuser[0];
            r_clock_line <= i_s_axis_tdata[0];
            r_data_line  <= i_s_axis_tdata[1];
            r_push_byte  <= i_s_axis_tdata[9:2];
            r_chunk_end  <= i_s_axis_tlast;
        end
        if (exec) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {3'b000, r_res};

    kssb_store #(
        .CHUNK_SLOTS (CHUNK_SLOTS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_store (
        .i_clk        (i_clk),
        .i_byte_we    (byte_we),
        .i_byte_waddr (byte_waddr),
        .i_byte_wdata (byte_wdata),
        .i_byte_raddr (byte_raddr),
        .o_byte_rdata (byte_rdata),
        .i_len_we     (len_we),
        .i_len_waddr  (len_waddr),
        .i_len_wdata  (len_wdata),
        .i_len_raddr  (len_raddr),
        .o_len_rdata  (len_rdata)
    );

    kssb_engine #(
        .CHUNK_SLOTS (CHUNK_SLOTS),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_exec        (exec),
        .i_action      (r_action),
        .i_clock_line  (r_clock_line),
        .i_data_line   (r_data_line),
        .i_push_byte   (r_push_byte),
        .i_chunk_end   (r_chunk_end),
        .i_rate_reload (r_rate_reload),
        .o_byte_we     (byte_we),
        .o_byte_waddr  (byte_waddr),
        .o_byte_wdata  (byte_wdata),
        .o_byte_raddr  (byte_raddr),
        .i_byte_rdata  (byte_rdata),
        .o_len_we      (len_we),
        .o_len_waddr   (len_waddr),
        .o_len_wdata   (len_wdata),
        .o_len_raddr   (len_raddr),
        .i_len_rdata   (len_rdata),
        .o_res         (res)
    );

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_m_valid)
        else $error("executed item left no result");

    a_exec_needs_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !exec)
        else $error("item executed before its memory read returned");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid && !i_m_axis_tready |=> r_m_valid && $stable(r_res))
        else $error("waiting result changed");

endmodule
